// ===== hdl/sssc_pkg.sv =====
// Shared types, constants and helpers for the servo soft-start speed cap block.
// No dependencies; imported by every module of the block except sssc_ram.
`timescale 1ns / 1ps

package sssc_pkg;

    localparam int SERVO_COUNT = 18;
    localparam int ADDR_W      = (SERVO_COUNT > 1) ? $clog2(SERVO_COUNT) : 1;
    localparam int CNT_W       = $clog2(SERVO_COUNT + 1);
    localparam int CFG_ADDR_W  = 5;

    localparam logic [5:0]  SERVO_LIMIT = 6'(SERVO_COUNT);
    localparam logic [9:0]  SPEED_MAX   = 10'd1023;
    localparam logic [15:0] POS_INVALID = 16'hFFFF;

    localparam logic [9:0]              RST_CAP_SPEED = 10'd100;
    localparam logic [15:0]             RST_JUMP_TH   = 16'd100;
    localparam logic [15:0]             RST_DONE_TH   = 16'd10;
    localparam logic [31:0]             RST_TIMEOUT   = 32'd3000;
    localparam logic [SERVO_COUNT-1:0]  RST_PRESENT   = '1;

    typedef enum logic [1:0] {
        ACT_COMMAND = 2'd0,
        ACT_TICK    = 2'd1,
        ACT_FLUSH   = 2'd2,
        ACT_RESTART = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        CFG_CAP_SPEED = 3'd0,
        CFG_JUMP_TH   = 3'd1,
        CFG_DONE_TH   = 3'd2,
        CFG_TIMEOUT   = 3'd3,
        CFG_PRESENT   = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [4:0]  servo_index;
        logic        addressed;
        logic [15:0] previous_goal;
        logic [15:0] new_goal;
        logic [15:0] speed_request;
        logic [15:0] position;
        logic [31:0] now_ms;
        logic        last_element;
        logic [7:0]  write_limit;
    } in_item_t;

    typedef struct packed {
        logic        write_valid;
        logic [4:0]  servo_id;
        logic [9:0]  speed_value;
        logic [4:0]  written_count;
        logic        converging_flag;
        logic        is_last;
    } out_item_t;

    typedef struct packed {
        logic [9:0]             cap_speed;
        logic [15:0]            jump_threshold;
        logic [15:0]            done_threshold;
        logic [31:0]            timeout_ms;
        logic [SERVO_COUNT-1:0] present_mask;
    } cfg_t;

    function automatic logic [15:0] abs_diff16(input logic [15:0] a, input logic [15:0] b);
        abs_diff16 = (a > b) ? (a - b) : (b - a);
    endfunction

endpackage

// ===== hdl/servo_soft_start_speed_cap.sv =====
// Top level of the servo soft-start speed cap block.
// Depends on sssc_pkg, sssc_regs, sssc_core (and sssc_ram below it).
`timescale 1ns / 1ps

// Soft-start speed limiter for SERVO_COUNT servos. Requested and last-written
// speeds live in two small RAMs with registered read data; per-entry valid bits
// make reset and restart take effect at once, with no clearing pass. Command and
// tick elements that do not end a batch, and restarts, are handled in the idle
// state. A batch end walks every entry once through the RAM read port. A flush
// scans pending marks one entry a cycle and spends one more RAM read per pending
// present servo before it closes; it stalls only while a result waits at the
// output. Configuration is written over the APB port at byte addresses 0x00
// (cap_speed) to 0x10 (present_mask).
module servo_soft_start_speed_cap
    import sssc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_data
);

    cfg_t cfg;

    sssc_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sssc_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// ===== hdl/sssc_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module sssc_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 18
) (
    input  logic                                          aclk,
    input  logic                                          we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
    input  logic [WIDTH-1:0]                              wdata,
    input  logic                                          re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
    output logic [WIDTH-1:0]                              rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hdl/sssc_regs.sv =====
// APB-style configuration register file for the soft-start speed cap block.
// Depends on sssc_pkg.
`timescale 1ns / 1ps

module sssc_regs
    import sssc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    cfg_idx_t reg_idx;
    logic     wr_en;

    assign pready  = 1'b1;
    assign reg_idx = cfg_idx_t'(paddr[4:2]);
    assign wr_en   = psel && penable && pwrite;
    assign cfg     = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (reg_idx)
                CFG_CAP_SPEED: cfg_next.cap_speed      = pwdata[9:0];
                CFG_JUMP_TH:   cfg_next.jump_threshold = pwdata[15:0];
                CFG_DONE_TH:   cfg_next.done_threshold = pwdata[15:0];
                CFG_TIMEOUT:   cfg_next.timeout_ms     = pwdata;
                CFG_PRESENT:   cfg_next.present_mask   = pwdata[SERVO_COUNT-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            CFG_CAP_SPEED: prdata = 32'(cfg_reg.cap_speed);
            CFG_JUMP_TH:   prdata = 32'(cfg_reg.jump_threshold);
            CFG_DONE_TH:   prdata = 32'(cfg_reg.done_threshold);
            CFG_TIMEOUT:   prdata = cfg_reg.timeout_ms;
            CFG_PRESENT:   prdata = 32'(cfg_reg.present_mask);
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.cap_speed      <= RST_CAP_SPEED;
            cfg_reg.jump_threshold <= RST_JUMP_TH;
            cfg_reg.done_threshold <= RST_DONE_TH;
            cfg_reg.timeout_ms     <= RST_TIMEOUT;
            cfg_reg.present_mask   <= RST_PRESENT;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== hdl/sssc_core.sv =====
// Item processing, pending-mark walk and flush walk over the per-servo speed RAMs.
// Depends on sssc_pkg and sssc_ram.
`timescale 1ns / 1ps

module sssc_core
    import sssc_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  cfg_t      cfg,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_MARK   = 5'b00010,
        ST_SCAN   = 5'b00100,
        ST_EVAL   = 5'b01000,
        ST_FINISH = 5'b10000
    } state_t;

    state_t                 state_reg, state_next;
    logic                   converging_reg, converging_next;
    logic [31:0]            engage_time_reg, engage_time_next;
    logic [SERVO_COUNT-1:0] pending_reg, pending_next;
    logic                   jump_seen_reg, jump_seen_next;
    logic                   valid_seen_reg, valid_seen_next;
    logic                   all_within_reg, all_within_next;
    logic [9:0]             restart_cap_reg, restart_cap_next;
    logic [SERVO_COUNT-1:0] req_vld_reg, req_vld_next;
    logic [SERVO_COUNT-1:0] wr_vld_reg, wr_vld_next;
    logic [CNT_W-1:0]       walk_idx_reg, walk_idx_next;
    logic                   eval_vld_reg, eval_vld_next;
    logic [ADDR_W-1:0]      eval_idx_reg, eval_idx_next;
    logic [7:0]             write_limit_reg, write_limit_next;
    logic [7:0]             written_reg, written_next;
    logic                   hold_vld_reg, hold_vld_next;
    out_item_t              hold_reg, hold_next;
    logic                   m_valid_reg, m_valid_next;
    out_item_t              m_data_reg, m_data_next;

    logic                   accept;
    action_t                action;
    logic [ADDR_W-1:0]      in_addr;
    logic                   in_range;
    logic [SERVO_COUNT-1:0] in_bit;
    logic                   present_in;
    logic                   cmd_write;
    logic [9:0]             req_clamped;
    logic                   cmd_jump;
    logic                   jump_eff;
    logic                   tick_hit;
    logic                   valid_eff;
    logic                   within_eff;
    logic [31:0]            elapsed;
    logic                   time_up;

    logic [ADDR_W-1:0]      walk_addr;
    logic [SERVO_COUNT-1:0] walk_bit;
    logic [SERVO_COUNT-1:0] eval_bit;
    logic                   walk_done;
    logic                   rd_en;
    logic [ADDR_W-1:0]      rd_addr;
    logic                   wr_we;
    logic [9:0]             req_rdata;
    logic [9:0]             wr_rdata;
    logic [9:0]             req_val;
    logic [9:0]             wr_val;
    logic [9:0]             target;
    logic                   differs;
    logic                   out_free;

    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign action    = action_t'(s_data.action);
    assign in_addr   = s_data.servo_index[ADDR_W-1:0];
    assign in_range  = ({1'b0, s_data.servo_index} < SERVO_LIMIT);
    assign in_bit    = SERVO_COUNT'(1) << s_data.servo_index;
    assign present_in = |(cfg.present_mask & in_bit);

    assign req_clamped = (s_data.speed_request > 16'(SPEED_MAX)) ? SPEED_MAX
                                                                 : s_data.speed_request[9:0];
    assign cmd_write = accept && (action == ACT_COMMAND) && in_range && s_data.addressed;
    assign cmd_jump  = in_range && s_data.addressed &&
                       (abs_diff16(s_data.new_goal, s_data.previous_goal) > cfg.jump_threshold);
    assign jump_eff  = jump_seen_reg || cmd_jump;

    assign tick_hit   = in_range && present_in && (s_data.position != POS_INVALID);
    assign valid_eff  = valid_seen_reg || tick_hit;
    assign within_eff = all_within_reg &&
        !(tick_hit && (abs_diff16(s_data.new_goal, s_data.position) > cfg.done_threshold));
    assign elapsed    = s_data.now_ms - engage_time_reg;
    assign time_up    = (elapsed >= cfg.timeout_ms);

    assign walk_addr = walk_idx_reg[ADDR_W-1:0];
    assign walk_bit  = SERVO_COUNT'(1) << walk_idx_reg;
    assign eval_bit  = SERVO_COUNT'(1) << eval_idx_reg;
    assign walk_done = (walk_idx_reg == CNT_W'(SERVO_COUNT));
    assign rd_addr   = walk_addr;

    // Never-written entries read as their restart values.
    assign req_val = (|(req_vld_reg & eval_bit)) ? req_rdata : 10'd0;
    assign wr_val  = (|(wr_vld_reg & eval_bit)) ? wr_rdata : restart_cap_reg;
    assign target  = (converging_reg && (req_val == 10'd0)) ? cfg.cap_speed : req_val;
    assign differs = (target != wr_val);

    assign out_free = !m_valid_reg || m_ready;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        state_next       = state_reg;
        converging_next  = converging_reg;
        engage_time_next = engage_time_reg;
        pending_next     = pending_reg;
        jump_seen_next   = jump_seen_reg;
        valid_seen_next  = valid_seen_reg;
        all_within_next  = all_within_reg;
        restart_cap_next = restart_cap_reg;
        req_vld_next     = req_vld_reg;
        wr_vld_next      = wr_vld_reg;
        walk_idx_next    = walk_idx_reg;
        eval_vld_next    = eval_vld_reg;
        eval_idx_next    = eval_idx_reg;
        write_limit_next = write_limit_reg;
        written_next     = written_reg;
        hold_vld_next    = hold_vld_reg;
        hold_next        = hold_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_data_next      = m_data_reg;
        rd_en            = 1'b0;
        wr_we            = 1'b0;

        if (cmd_write) begin
            req_vld_next = req_vld_reg | in_bit;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    unique case (action)
                        ACT_COMMAND: begin
                            jump_seen_next = jump_eff;
                            if (s_data.last_element) begin
                                if (jump_eff) begin
                                    converging_next  = 1'b1;
                                    engage_time_next = s_data.now_ms;
                                end
                                jump_seen_next  = 1'b0;
                                valid_seen_next = 1'b0;
                                all_within_next = 1'b1;
                                walk_idx_next   = '0;
                                eval_vld_next   = 1'b0;
                                state_next      = ST_MARK;
                            end
                        end
                        ACT_TICK: begin
                            valid_seen_next = valid_eff;
                            all_within_next = within_eff;
                            if (s_data.last_element) begin
                                if (converging_reg && ((valid_eff && within_eff) || time_up)) begin
                                    converging_next = 1'b0;
                                end
                                jump_seen_next  = 1'b0;
                                valid_seen_next = 1'b0;
                                all_within_next = 1'b1;
                                walk_idx_next   = '0;
                                eval_vld_next   = 1'b0;
                                state_next      = ST_MARK;
                            end
                        end
                        ACT_FLUSH: begin
                            write_limit_next = s_data.write_limit;
                            written_next     = 8'd0;
                            walk_idx_next    = '0;
                            state_next       = ST_SCAN;
                        end
                        ACT_RESTART: begin
                            converging_next  = 1'b1;
                            engage_time_next = s_data.now_ms;
                            pending_next     = '0;
                            req_vld_next     = '0;
                            wr_vld_next      = '0;
                            restart_cap_next = cfg.cap_speed;
                            jump_seen_next   = 1'b0;
                            valid_seen_next  = 1'b0;
                            all_within_next  = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end

            // Read entry n while comparing entry n-1.
            ST_MARK: begin
                if (eval_vld_reg && differs) begin
                    pending_next = pending_reg | eval_bit;
                end
                if (walk_done) begin
                    eval_vld_next = 1'b0;
                    state_next    = ST_IDLE;
                end else begin
                    rd_en         = 1'b1;
                    walk_idx_next = walk_idx_reg + CNT_W'(1);
                    eval_vld_next = 1'b1;
                    eval_idx_next = walk_addr;
                end
            end

            ST_SCAN: begin
                priority if (walk_done || (written_reg >= write_limit_reg)) begin
                    state_next = ST_FINISH;
                end else if (!(|(pending_reg & walk_bit))) begin
                    walk_idx_next = walk_idx_reg + CNT_W'(1);
                end else if (!(|(cfg.present_mask & walk_bit))) begin
                    pending_next  = pending_reg & ~walk_bit;
                    walk_idx_next = walk_idx_reg + CNT_W'(1);
                end else begin
                    rd_en         = 1'b1;
                    eval_idx_next = walk_addr;
                    state_next    = ST_EVAL;
                end
            end

            // The held result goes out only once the next one shows it was not the last.
            ST_EVAL: begin
                if (!differs) begin
                    pending_next  = pending_reg & ~eval_bit;
                    walk_idx_next = walk_idx_reg + CNT_W'(1);
                    state_next    = ST_SCAN;
                end else if (!hold_vld_reg || out_free) begin
                    if (hold_vld_reg) begin
                        m_valid_next = 1'b1;
                        m_data_next  = hold_reg;
                    end
                    wr_we         = 1'b1;
                    wr_vld_next   = wr_vld_reg | eval_bit;
                    written_next  = written_reg + 8'd1;
                    hold_vld_next = 1'b1;
                    hold_next.write_valid     = 1'b1;
                    hold_next.servo_id        = 5'(eval_idx_reg) + 5'd1;
                    hold_next.speed_value     = target;
                    hold_next.written_count   = written_next[4:0];
                    hold_next.converging_flag = converging_reg;
                    hold_next.is_last         = 1'b0;
                    pending_next  = pending_reg & ~eval_bit;
                    walk_idx_next = walk_idx_reg + CNT_W'(1);
                    state_next    = ST_SCAN;
                end
            end

            ST_FINISH: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    if (hold_vld_reg) begin
                        m_data_next         = hold_reg;
                        m_data_next.is_last = 1'b1;
                    end else begin
                        m_data_next.write_valid     = 1'b0;
                        m_data_next.servo_id        = 5'd0;
                        m_data_next.speed_value     = 10'd0;
                        m_data_next.written_count   = 5'd0;
                        m_data_next.converging_flag = converging_reg;
                        m_data_next.is_last         = 1'b1;
                    end
                    hold_vld_next = 1'b0;
                    state_next    = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    // Accesses never touch one entry in back-to-back cycles except a command write
    // followed by its batch-end walk, which may read the entry just written.
    sssc_ram #(
        .WIDTH (10),
        .DEPTH (SERVO_COUNT)
    ) u_req_ram (
        .aclk  (aclk),
        .we    (cmd_write),
        .waddr (in_addr),
        .wdata (req_clamped),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (req_rdata)
    );

    sssc_ram #(
        .WIDTH (10),
        .DEPTH (SERVO_COUNT)
    ) u_wr_ram (
        .aclk  (aclk),
        .we    (wr_we),
        .waddr (eval_idx_reg),
        .wdata (target),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (wr_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            converging_reg  <= 1'b1;
            engage_time_reg <= 32'd0;
            pending_reg     <= '0;
            jump_seen_reg   <= 1'b0;
            valid_seen_reg  <= 1'b0;
            all_within_reg  <= 1'b1;
            restart_cap_reg <= RST_CAP_SPEED;
            req_vld_reg     <= '0;
            wr_vld_reg      <= '0;
            eval_vld_reg    <= 1'b0;
            hold_vld_reg    <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            converging_reg  <= converging_next;
            engage_time_reg <= engage_time_next;
            pending_reg     <= pending_next;
            jump_seen_reg   <= jump_seen_next;
            valid_seen_reg  <= valid_seen_next;
            all_within_reg  <= all_within_next;
            restart_cap_reg <= restart_cap_next;
            req_vld_reg     <= req_vld_next;
            wr_vld_reg      <= wr_vld_next;
            eval_vld_reg    <= eval_vld_next;
            hold_vld_reg    <= hold_vld_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        walk_idx_reg    <= walk_idx_next;
        eval_idx_reg    <= eval_idx_next;
        write_limit_reg <= write_limit_next;
        written_reg     <= written_next;
        hold_reg        <= hold_next;
        m_data_reg      <= m_data_next;
    end

`ifndef SYNTH
    a_hold_empty_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !hold_vld_reg)
        else $error("held item left over outside a flush");

    a_write_budget: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_SCAN) || (state_reg == ST_EVAL) || (state_reg == ST_FINISH))
        |-> (written_reg <= write_limit_reg))
        else $error("flush exceeded its write limit");

    a_empty_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_data_reg.write_valid) |-> m_data_reg.is_last)
        else $error("non-write item not marked last");

    a_restart_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (action == ACT_RESTART))
        |=> ((pending_reg == '0) && converging_reg && (wr_vld_reg == '0)))
        else $error("restart did not clear pending state");
`endif

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for servo_soft_start_speed_cap: directed table, then random
// command/tick/flush/restart traffic over several register settings, checked by a local predictor.
// Depends on sssc_pkg and the servo_soft_start_speed_cap RTL.
`timescale 1ns / 1ps

module testbench
    import sssc_pkg::*;
();

    typedef struct {
        in_item_t item;
        bit       no_write;   // flush known to give the single no-write result, converging
    } stim_t;

    localparam out_item_t IDLE_FLUSH = '{write_valid: 1'b0, servo_id: 5'd0, speed_value: 10'd0,
                                         written_count: 5'd0, converging_flag: 1'b1,
                                         is_last: 1'b1};

    logic                  aclk    = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr   = '0;
    logic [31:0]           pwdata  = '0;
    logic [31:0]           prdata;
    logic                  pready;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    in_item_t              s_data  = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    out_item_t             m_data;

    servo_soft_start_speed_cap dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    initial begin
        #10_000_000;
        $display("testbench: done, errors");
        $finish;
    end

    // predictor copy of registers and state
    logic [9:0]             cap_spd;
    logic [15:0]            jump_th;
    logic [15:0]            done_th;
    logic [31:0]            tmo_ms;
    logic [SERVO_COUNT-1:0] present;
    bit                     conv;
    logic [31:0]            engage_ms;
    logic [9:0]             req_spd [SERVO_COUNT];
    logic [9:0]             wr_spd [SERVO_COUNT];
    logic [SERVO_COUNT-1:0] pend;
    bit                     jump_hit;
    bit                     seen_valid;
    bit                     all_near;

    out_item_t speed_writes_q[$];
    stim_t     stim_q[$];
    stim_t     cur;
    int        n_pushed   = 0;
    int        n_accepted = 0;
    int        n_err      = 0;
    int        burst_left = 0;
    int        gap_left   = 0;
    logic [4:0] stall_ph  = '0;
    logic [7:0] stall_pat = 8'hFF;

    // stimulus generator state
    logic [31:0] tb_now = '0;
    logic [15:0] goal_of [SERVO_COUNT];

    function automatic logic [9:0] tgt_of(int i);
        return (conv && req_spd[i] == '0) ? cap_spd : req_spd[i];
    endfunction

    function automatic logic [15:0] span16(logic [15:0] a, logic [15:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    task automatic close_batch();
        for (int i = 0; i < SERVO_COUNT; i++) begin
            if (tgt_of(i) != wr_spd[i]) pend[i] = 1'b1;
        end
        jump_hit   = 1'b0;
        seen_valid = 1'b0;
        all_near   = 1'b1;
    endtask

    task automatic soft_restart(logic [31:0] now);
        conv      = 1'b1;
        engage_ms = now;
        pend      = '0;
        for (int i = 0; i < SERVO_COUNT; i++) begin
            wr_spd[i]  = cap_spd;
            req_spd[i] = '0;
        end
        jump_hit   = 1'b0;
        seen_valid = 1'b0;
        all_near   = 1'b1;
    endtask

    task automatic reset_model();
        cap_spd = RST_CAP_SPEED;
        jump_th = RST_JUMP_TH;
        done_th = RST_DONE_TH;
        tmo_ms  = RST_TIMEOUT;
        present = RST_PRESENT;
        soft_restart('0);
    endtask

    task automatic predict_speed_writes(stim_t s);
        in_item_t  it;
        bit        in_rng;
        int        cnt;
        out_item_t o;
        out_item_t res[$];
        it     = s.item;
        in_rng = it.servo_index < SERVO_COUNT;
        case (action_t'(it.action))
            ACT_COMMAND: begin
                if (in_rng && it.addressed) begin
                    req_spd[it.servo_index] = (it.speed_request > 16'(SPEED_MAX)) ?
                                              SPEED_MAX : it.speed_request[9:0];
                    if (span16(it.new_goal, it.previous_goal) > jump_th) jump_hit = 1'b1;
                end
                if (it.last_element) begin
                    if (jump_hit) begin
                        conv      = 1'b1;
                        engage_ms = it.now_ms;
                    end
                    close_batch();
                end
            end
            ACT_TICK: begin
                if (in_rng && present[it.servo_index] && it.position != POS_INVALID) begin
                    seen_valid = 1'b1;
                    if (span16(it.new_goal, it.position) > done_th) all_near = 1'b0;
                end
                if (it.last_element) begin
                    if (conv && ((seen_valid && all_near) || (it.now_ms - engage_ms) >= tmo_ms))
                        conv = 1'b0;
                    close_batch();
                end
            end
            ACT_RESTART: soft_restart(it.now_ms);
            default: begin
                cnt = 0;
                for (int i = 0; i < SERVO_COUNT && cnt < int'(it.write_limit); i++) begin
                    if (!pend[i]) continue;
                    // absent servos just lose their mark
                    if (present[i] && tgt_of(i) != wr_spd[i]) begin
                        wr_spd[i] = tgt_of(i);
                        cnt++;
                        o                 = '0;
                        o.write_valid     = 1'b1;
                        o.servo_id        = 5'(i + 1);
                        o.speed_value     = wr_spd[i];
                        o.written_count   = 5'(cnt);
                        o.converging_flag = conv;
                        res.push_back(o);
                    end
                    pend[i] = 1'b0;
                end
                if (res.size() == 0) begin
                    o                 = '0;
                    o.converging_flag = conv;
                    o.is_last         = 1'b1;
                    res.push_back(o);
                end else begin
                    res[res.size() - 1].is_last = 1'b1;
                end
                if (s.no_write) speed_writes_q.push_back(IDLE_FLUSH);
                else foreach (res[k]) speed_writes_q.push_back(res[k]);
            end
        endcase
    endtask

    function automatic string show(out_item_t o);
        return $sformatf("wv=%0d id=%0d speed=%0d count=%0d conv=%0d last=%0d", o.write_valid,
                         o.servo_id, o.speed_value, o.written_count, o.converging_flag,
                         o.is_last);
    endfunction

    task automatic flag_error(string msg);
        n_err++;
        if (n_err <= 10) $display("mismatch: %s", msg);
    endtask

    // sender: bursts of items separated by random gaps
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                predict_speed_writes(cur);
                n_accepted++;
            end
            if (!(s_valid && !s_ready)) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (stim_q.size() > 0) begin
                    cur = stim_q.pop_front();
                    s_data  <= cur.item;
                    s_valid <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 15);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: stall pattern redrawn each time the 5-bit phase counter wraps, sometimes all-ready
    always @(posedge aclk) begin
        stall_ph <= stall_ph + 5'd1;
        if (stall_ph == '0)
            stall_pat <= ($urandom_range(0, 2) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
        m_ready <= stall_pat[stall_ph[2:0]];
    end

    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (speed_writes_q.size() == 0) begin
                flag_error($sformatf("unexpected result %s", show(m_data)));
            end else begin
                want = speed_writes_q.pop_front();
                if (m_data.write_valid !== want.write_valid || m_data.servo_id !== want.servo_id ||
                    m_data.speed_value !== want.speed_value ||
                    m_data.written_count !== want.written_count ||
                    m_data.converging_flag !== want.converging_flag ||
                    m_data.is_last !== want.is_last)
                    flag_error($sformatf("expected %s, got %s", show(want), show(m_data)));
            end
        end
    end

    task automatic reg_write(cfg_idx_t idx, logic [31:0] val);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_W'(4 * int'(idx));
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            CFG_CAP_SPEED: cap_spd = val[9:0];
            CFG_JUMP_TH:   jump_th = val[15:0];
            CFG_DONE_TH:   done_th = val[15:0];
            CFG_TIMEOUT:   tmo_ms  = val;
            CFG_PRESENT:   present = val[SERVO_COUNT-1:0];
            default: ;
        endcase
    endtask

    task automatic push_item(in_item_t it, bit no_write = 1'b0);
        stim_t s;
        s.item     = it;
        s.no_write = no_write;
        stim_q.push_back(s);
        n_pushed++;
    endtask

    // wait until the block is idle
    task automatic drain();
        while (n_accepted != n_pushed || speed_writes_q.size() != 0) @(posedge aclk);
        repeat (48) @(posedge aclk);
    endtask

    function automatic stim_t row(action_t act, int sv, bit adr, int pg, int ng, int sp,
                                  int ps, int unsigned now, bit last, int mw, bit no_write);
        stim_t s;
        s.item               = '0;
        s.item.action        = act;
        s.item.servo_index   = 5'(sv);
        s.item.addressed     = adr;
        s.item.previous_goal = 16'(pg);
        s.item.new_goal      = 16'(ng);
        s.item.speed_request = 16'(sp);
        s.item.position      = 16'(ps);
        s.item.now_ms        = now;
        s.item.last_element  = last;
        s.item.write_limit   = 8'(mw);
        s.no_write           = no_write;
        return s;
    endfunction

    function automatic in_item_t rand_item();
        in_item_t it;
        it.action        = 2'($urandom);
        it.servo_index   = 5'($urandom);
        it.addressed     = 1'($urandom);
        it.previous_goal = 16'($urandom);
        it.new_goal      = 16'($urandom);
        it.speed_request = 16'($urandom);
        it.position      = 16'($urandom);
        it.now_ms        = $urandom;
        it.last_element  = 1'($urandom);
        it.write_limit   = 8'($urandom);
        return it;
    endfunction

    function automatic logic [4:0] pick_servo();
        return ($urandom_range(0, 19) == 0) ? 5'($urandom_range(SERVO_COUNT, 31)) :
                                              5'($urandom_range(0, SERVO_COUNT - 1));
    endfunction

    // mostly well-formed command and tick batches with flushes, plus restarts and noise
    task automatic gen_traffic(int n_items);
        int         made;
        int         sel;
        int         k;
        in_item_t   it;
        logic [4:0] idx;
        made = 0;
        while (made < n_items) begin
            sel = $urandom_range(0, 99);
            if ($urandom_range(0, 19) == 0) tb_now = $urandom;
            else tb_now += $urandom_range(0, 600);
            if (sel < 65) begin
                k = $urandom_range(1, 5);
                for (int j = 0; j < k; j++) begin
                    it              = rand_item();
                    idx             = pick_servo();
                    it.servo_index  = idx;
                    it.now_ms       = tb_now;
                    // now and then leave the batch open into the next one
                    it.last_element = (j == k - 1) && ($urandom_range(0, 9) != 0);
                    if (sel < 35) begin
                        it.action    = ACT_COMMAND;
                        it.addressed = ($urandom_range(0, 5) != 0);
                        if (idx < SERVO_COUNT) it.previous_goal = goal_of[idx];
                        if ($urandom_range(0, 4) != 0)
                            it.new_goal = it.previous_goal + 16'($urandom_range(0, 240)) - 16'd120;
                        case ($urandom_range(0, 4))
                            0: it.speed_request = '0;
                            1, 2, 3: it.speed_request = 16'($urandom_range(1, 1023));
                            default: ;
                        endcase
                        if (idx < SERVO_COUNT && it.addressed) goal_of[idx] = it.new_goal;
                    end else begin
                        it.action = ACT_TICK;
                        if (idx < SERVO_COUNT) it.new_goal = goal_of[idx];
                        case ($urandom_range(0, 9))
                            0: it.position = POS_INVALID;
                            1, 2: ;
                            default:
                                it.position = it.new_goal + 16'($urandom_range(0, 24)) - 16'd12;
                        endcase
                    end
                    push_item(it);
                    made++;
                end
            end else begin
                it        = rand_item();
                it.now_ms = tb_now;
                if (sel < 90) begin
                    it.action = ACT_FLUSH;
                    case ($urandom_range(0, 4))
                        0, 1: it.write_limit = 8'd255;
                        2: it.write_limit = 8'($urandom_range(0, 3));
                        3: it.write_limit = 8'($urandom_range(4, SERVO_COUNT));
                        default: ;
                    endcase
                end else if (sel < 94) begin
                    it.action = ACT_RESTART;
                end
                push_item(it);
                made++;
            end
        end
    endtask

    initial begin
        stim_t dir_tab[$];
        foreach (goal_of[i]) goal_of[i] = '0;
        reset_model();

        //                      act          idx adr prev   goal   speed  pos    now    lst max nw
        dir_tab.push_back(row(ACT_FLUSH,    0,  0,  0,     0,     0,     0,     0,     0, 18, 1));
        dir_tab.push_back(row(ACT_COMMAND,  0,  1,  0,     65535, 65535, 0,     10,    0, 0,  0));
        dir_tab.push_back(row(ACT_COMMAND,  17, 1,  200,   250,   0,     0,     10,    0, 0,  0));
        // out-of-range index still closes the batch
        dir_tab.push_back(row(ACT_COMMAND,  31, 1,  0,     65535, 500,   0,     20,    1, 0,  0));
        dir_tab.push_back(row(ACT_FLUSH,    0,  0,  0,     0,     0,     0,     0,     0, 0,  1));
        dir_tab.push_back(row(ACT_FLUSH,    0,  0,  0,     0,     0,     0,     0,     0, 255, 0));
        dir_tab.push_back(row(ACT_COMMAND,  5,  0,  0,     0,     7,     0,     30,    1, 0,  0));
        dir_tab.push_back(row(ACT_COMMAND,  3,  1,  100,   200,   1,     0,     30,    1, 0,  0));
        dir_tab.push_back(row(ACT_FLUSH,    0,  0,  0,     0,     0,     0,     0,     0, 1,  0));
        dir_tab.push_back(row(ACT_TICK,     0,  0,  0,     1000,  0,     65535, 40,    0, 0,  0));
        dir_tab.push_back(row(ACT_TICK,     1,  0,  0,     500,   0,     510,   40,    1, 0,  0));
        dir_tab.push_back(row(ACT_FLUSH,    0,  0,  0,     0,     0,     0,     0,     0, 3,  0));
        dir_tab.push_back(row(ACT_FLUSH,    0,  0,  0,     0,     0,     0,     0,     0, 255, 0));
        // tick while released: no effect
        dir_tab.push_back(row(ACT_TICK,     2,  0,  0,     0,     0,     40000, 50,    1, 0,  0));
        dir_tab.push_back(row(ACT_COMMAND,  2,  1,  0,     65535, 0,     0,     5000,  1, 0,  0));
        dir_tab.push_back(row(ACT_TICK,     4,  0,  0,     65535, 0,     0,     7999,  1, 0,  0));
        // timeout exactly reached
        dir_tab.push_back(row(ACT_TICK,     31, 0,  0,     0,     0,     0,     8000,  1, 0,  0));
        dir_tab.push_back(row(ACT_FLUSH,    0,  0,  0,     0,     0,     0,     0,     0, 255, 0));
        dir_tab.push_back(row(ACT_RESTART,  0,  0,  0,     0,     0,     0,     12345, 0, 0,  0));
        dir_tab.push_back(row(ACT_FLUSH,    0,  0,  0,     0,     0,     0,     0,     0, 18, 1));
        dir_tab.push_back(row(ACT_TICK,     0,  0,  0,     0,     0,     65535, 12346, 1, 0,  0));
        dir_tab.push_back(row(ACT_FLUSH,    0,  0,  0,     0,     0,     0,     0,     0, 255, 1));

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_tab[k]) push_item(dir_tab[k].item, dir_tab[k].no_write);
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin
                    reg_write(CFG_CAP_SPEED, 32'd0);
                    reg_write(CFG_JUMP_TH, 32'd0);
                    reg_write(CFG_DONE_TH, 32'd0);
                    reg_write(CFG_TIMEOUT, 32'd0);
                    reg_write(CFG_PRESENT, 32'd0);
                end
                1: begin
                    reg_write(CFG_CAP_SPEED, 32'd1023);
                    reg_write(CFG_JUMP_TH, 32'd65535);
                    reg_write(CFG_DONE_TH, 32'd65535);
                    reg_write(CFG_TIMEOUT, 32'hFFFF_FFFF);
                    reg_write(CFG_PRESENT, 32'(RST_PRESENT));
                end
                default: begin
                    reg_write(CFG_CAP_SPEED, $urandom_range(1, 1022));
                    reg_write(CFG_JUMP_TH, $urandom_range(0, 2000));
                    reg_write(CFG_DONE_TH, $urandom_range(0, 300));
                    reg_write(CFG_TIMEOUT, $urandom_range(0, 5000));
                    reg_write(CFG_PRESENT, 32'($urandom | $urandom) & 32'h3FFFF);
                end
            endcase
            gen_traffic(35);
            drain();
        end

        if (n_err == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule
